// ===== design/sdvc_pkg.sv =====
// Shared constants for the sorted distinct value counter.
`default_nettype none

package sdvc_pkg;

    // Default set size and stored value width.
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 10;

    // Fixed widths of the words on the ports.
    localparam int VALUE_W = 10;
    localparam int COUNT_W = 5;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== design/sdvc_front.sv =====
// Front part: takes input words, trims the value and tags the word that ends a set.
`default_nettype none

module sdvc_front
    import sdvc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic                  last_item,
    input  wire logic                  queue_full,
    output logic                       push,
    output logic [VALUE_BITS-1:0]      push_value,
    output logic                       push_ends_set
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] items_reg;
    logic [CW-1:0] items_next;

    // The input side waits only while the queue has no room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Keep the low VALUE_BITS bits of the value, zero filling above the port width.
    genvar i;
    for (i = 0; i < VALUE_BITS; i++) begin : g_bit
        if (i < VALUE_W) begin : g_copy
            assign push_value[i] = value[i];
        end
        else begin : g_zero
            assign push_value[i] = 1'b0;
        end
    end

    // A set ends on a marked word or on the word that fills the capacity.
    assign push_ends_set = last_item || (items_reg == CW'(CAPACITY - 1));

    always_comb
    begin
        items_next = items_reg;
        if (push) begin
            if (push_ends_set) begin
                items_next = '0;
            end
            else begin
                items_next = items_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            items_reg <= '0;
        end
        else begin
            items_reg <= items_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sdvc_queue.sv =====
// Short queue of classified words between the front and back parts.
`default_nettype none

module sdvc_queue
    import sdvc_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEF + 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    fill_reg;
    logic [NW-1:0]    fill_next;

    assign full      = (fill_reg == NW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push) begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/sdvc_back.sv =====
// Back part: sorted cell chain that counts values, then shifts out the report.
`default_nettype none

module sdvc_back
    import sdvc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_not_empty,
    input  wire logic [VALUE_BITS-1:0] q_value,
    input  wire logic                  q_ends_set,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VALUE_W-1:0]         distinct_value,
    output logic [COUNT_W-1:0]         occurrences,
    output logic                       last_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic MODE_FILL   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    logic                  mode_reg;
    logic                  mode_next;
    logic [CW-1:0]         total_reg;
    logic [CW-1:0]         total_next;
    logic [VALUE_BITS-1:0] val_reg  [CAPACITY];
    logic [VALUE_BITS-1:0] val_next [CAPACITY];
    logic [CW-1:0]         cnt_reg  [CAPACITY];
    logic [CW-1:0]         cnt_next [CAPACITY];
    logic [CAPACITY-1:0]   lt;
    logic [CAPACITY-1:0]   eq;
    logic                  hit;
    logic                  drain;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [CW-1:0]         out_cnt_reg;
    logic                  out_last_reg;

    // Words are taken from the queue only while a set is being filled.
    assign q_pop = (mode_reg == MODE_FILL) && q_not_empty;

    // The report moves one word forward whenever the output register is free.
    assign drain = (mode_reg == MODE_REPORT) && (!out_valid_reg || !out_stall);

    assign hit = |eq;

    // Per cell compare, insert and shift logic.
    genvar k;
    for (k = 0; k < CAPACITY; k++) begin : g_cell
        logic                  cell_live;
        logic                  prev_lt;
        logic [VALUE_BITS-1:0] prev_val;
        logic [CW-1:0]         prev_cnt;
        logic [VALUE_BITS-1:0] succ_val;
        logic [CW-1:0]         succ_cnt;

        assign cell_live = (CW'(k) < total_reg);
        assign lt[k]     = cell_live && (val_reg[k] < q_value);
        assign eq[k]     = cell_live && (val_reg[k] == q_value);

        if (k == 0) begin : g_head
            assign prev_lt  = 1'b1;
            assign prev_val = q_value;
            assign prev_cnt = CW'(1);
        end
        else begin : g_body
            assign prev_lt  = lt[k-1];
            assign prev_val = val_reg[k-1];
            assign prev_cnt = cnt_reg[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign succ_val = val_reg[k];
            assign succ_cnt = cnt_reg[k];
        end
        else begin : g_inner
            assign succ_val = val_reg[k+1];
            assign succ_cnt = cnt_reg[k+1];
        end

        always_comb
        begin
            val_next[k] = val_reg[k];
            cnt_next[k] = cnt_reg[k];
            if (q_pop) begin
                if (hit) begin
                    if (eq[k]) begin
                        cnt_next[k] = cnt_reg[k] + CW'(1);
                    end
                end
                else if (!lt[k]) begin
                    if (prev_lt) begin
                        val_next[k] = q_value;
                        cnt_next[k] = CW'(1);
                    end
                    else begin
                        val_next[k] = prev_val;
                        cnt_next[k] = prev_cnt;
                    end
                end
            end
            else if (drain) begin
                val_next[k] = succ_val;
                cnt_next[k] = succ_cnt;
            end
        end
    end

    // Mode and fill count of the chain.
    always_comb
    begin
        mode_next  = mode_reg;
        total_next = total_reg;
        unique case (mode_reg)
            MODE_FILL:
            begin
                if (q_pop) begin
                    if (!hit) begin
                        total_next = total_reg + CW'(1);
                    end
                    if (q_ends_set) begin
                        mode_next = MODE_REPORT;
                    end
                end
            end
            MODE_REPORT:
            begin
                if (drain) begin
                    total_next = total_reg - CW'(1);
                    if (total_reg == CW'(1)) begin
                        mode_next = MODE_FILL;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_FILL;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            mode_reg  <= mode_next;
            total_reg <= total_next;
            if (drain) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Cell contents and the output word carry no reset.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < CAPACITY; j++) begin
            val_reg[j] <= val_next[j];
            cnt_reg[j] <= cnt_next[j];
        end
        if (drain) begin
            out_val_reg  <= val_reg[0];
            out_cnt_reg  <= cnt_reg[0];
            out_last_reg <= (total_reg == CW'(1));
        end
    end

    // Fit the stored widths to the port widths.
    assign out_valid   = out_valid_reg;
    assign last_result = out_last_reg;

    genvar b;
    for (b = 0; b < VALUE_W; b++) begin : g_out_val
        if (b < VALUE_BITS) begin : g_copy
            assign distinct_value[b] = out_val_reg[b];
        end
        else begin : g_zero
            assign distinct_value[b] = 1'b0;
        end
    end

    for (b = 0; b < COUNT_W; b++) begin : g_out_cnt
        if (b < CW) begin : g_copy
            assign occurrences[b] = out_cnt_reg[b];
        end
        else begin : g_zero
            assign occurrences[b] = 1'b0;
        end
    end

    // The chain never holds more cells than the set size.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(CAPACITY))
    else $error("cell chain overfilled");

    // A report is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_REPORT) |-> (total_reg != '0))
    else $error("report mode with an empty chain");

    // The word flagged as last empties the chain and reopens filling.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain && (total_reg == CW'(1))) |=> (mode_reg == MODE_FILL) && (total_reg == '0))
    else $error("chain not empty after final word");

    // The queue is never read while a report is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !drain)
    else $error("insert and report in the same cycle");

    // The two lowest cells stay in strictly ascending order.
    if (CAPACITY > 1) begin : g_order_check
        assert property (@(posedge clk) disable iff (!rst_n)
            (total_reg >= CW'(2)) |-> (val_reg[0] < val_reg[1]))
        else $error("cell chain out of order");
    end

endmodule

`default_nettype wire

// ===== design/sorted_distinct_value_counter_unit.sv =====
// Top level of the sorted distinct value counter.
// A word that ends a set passes through the queue and the cell insert before its first result word is registered.
// Throughput: one input word per cycle while a set fills, as the cell chain takes a queued word while filling.
// The report then drains one result word per cycle while the output is not stalled, by shifting the cell chain down.
// Input words are taken into a two-word queue while the report drains, until the queue is full.
// Reset clears the fill count, the set counter, the queue and the output valid at once.
`default_nettype none

module sorted_distinct_value_counter_unit
    import sdvc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               last_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [VALUE_W-1:0]      distinct_value,
    output logic [COUNT_W-1:0]      occurrences,
    output logic                    last_result
);

    logic                  queue_full;
    logic                  push;
    logic [VALUE_BITS-1:0] push_value;
    logic                  push_ends_set;
    logic                  pop;
    logic [VALUE_BITS:0]   pop_data;
    logic                  not_empty;

    // Input classification.
    sdvc_front #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .last_item     (last_item),
        .queue_full    (queue_full),
        .push          (push),
        .push_value    (push_value),
        .push_ends_set (push_ends_set)
    );

    // Queue between the two parts.
    sdvc_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ends_set, push_value}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // Counting chain and report.
    sdvc_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (not_empty),
        .q_value        (pop_data[VALUE_BITS-1:0]),
        .q_ends_set     (pop_data[VALUE_BITS]),
        .q_pop          (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distinct_value (distinct_value),
        .occurrences    (occurrences),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire

// ===== bench/sorted_distinct_value_counter_unit_tb.sv =====
// Self-checking testbench for the sorted distinct value counter unit.
`timescale 1ns / 100ps

module sorted_distinct_value_counter_unit_tb;
    import sdvc_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_WORDS = 136;
    localparam int IDLE_PERCENT = 30;

    // One expected word of the report.
    typedef struct packed {
        logic [VALUE_W-1:0] dv;
        logic [COUNT_W-1:0] occ;
        logic               fin;
    } report_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value = '0;
    logic               last_item = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] distinct_value;
    logic [COUNT_W-1:0] occurrences;
    logic               last_result;

    // Shadow of the sorted cell chain.
    logic [VALUE_W-1:0] tally_value [CAPACITY];
    int                 tally_count [CAPACITY];
    int                 tally_held = 0;
    int                 tally_items = 0;

    report_word_t       pending_reports [$];

    bit calm = 1'b0;
    int mismatches = 0;
    int words_sent = 0;
    int sets_closed = 0;
    int reports_checked = 0;
    int quiet_cycles = 0;

    sorted_distinct_value_counter_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distinct_value (distinct_value),
        .occurrences    (occurrences),
        .last_result    (last_result)
    );

    // Free-running clock.
    always #HALF_PERIOD clk = ~clk;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Inserts one accepted word into the shadow chain and queues the report when the set closes.
    task automatic tally_word(input logic [VALUE_W-1:0] v, input logic fin);
        logic [VALUE_W-1:0] vm;
        int                 pos;
        int                 k;
        report_word_t       rw;
        begin
            vm = v & VALUE_W'((1 << VALUE_BITS) - 1);
            pos = 0;
            while (pos < tally_held && tally_value[pos] < vm)
            begin
                pos++;
            end
            if (pos < tally_held && tally_value[pos] == vm)
            begin
                tally_count[pos]++;
            end
            else
            begin
                for (k = tally_held; k > pos; k--)
                begin
                    tally_value[k] = tally_value[k - 1];
                    tally_count[k] = tally_count[k - 1];
                end
                tally_value[pos] = vm;
                tally_count[pos] = 1;
                tally_held++;
            end
            tally_items++;

            // A set closes on a marked word or when the chain has taken a full set.
            if (fin || tally_items >= CAPACITY)
            begin
                for (k = 0; k < tally_held; k++)
                begin
                    rw.dv  = tally_value[k];
                    rw.occ = COUNT_W'(tally_count[k]);
                    rw.fin = (k + 1 == tally_held);
                    pending_reports.push_back(rw);
                end
                tally_held = 0;
                tally_items = 0;
                sets_closed++;
            end
        end
    endtask

    // Offers one word, waits for it to be taken and updates the prediction.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic fin);
        begin
            while (!calm && $urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            value     <= v;
            last_item <= fin;
            do
            begin
                @(posedge clk);
            end
            while (in_stall);
            tally_word(v, fin);
            words_sent++;
        end
    endtask

    // Result side: checks each taken word, then chooses the next stall.
    always @(posedge clk)
    begin
        report_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d count %0d last %0b",
                                          distinct_value, occurrences, last_result));
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (distinct_value !== want.dv)
                begin
                    report_mismatch($sformatf("distinct_value %0d, expected %0d",
                                              distinct_value, want.dv));
                end
                if (occurrences !== want.occ)
                begin
                    report_mismatch($sformatf("occurrences %0d for value %0d, expected %0d",
                                              occurrences, want.dv, want.occ));
                end
                if (last_result !== want.fin)
                begin
                    report_mismatch($sformatf("last_result %0b for value %0d, expected %0b",
                                              last_result, want.dv, want.fin));
                end
            end
        end
        if (rst_n)
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Extremes of the value field, repeats and a set of one word.
    task automatic test_extremes();
        begin
            send_word('0, 1'b1);
            send_word('1, 1'b1);
            send_word(VALUE_W'(1023), 1'b0);
            send_word(VALUE_W'(0), 1'b0);
            send_word(VALUE_W'(1023), 1'b0);
            send_word(VALUE_W'(512), 1'b1);
            send_word(VALUE_W'(341), 1'b0);
            send_word(VALUE_W'(682), 1'b1);
        end
    endtask

    // A full set of one repeated value closes without a last marker.
    task automatic test_capacity_close();
        int k;
        begin
            for (k = 0; k < CAPACITY; k++)
            begin
                send_word(VALUE_W'(1023), 1'b0);
            end
        end
    endtask

    // Random sets: mostly short, some full, with narrow and wide value spreads.
    task automatic test_random_sets();
        int target;
        int len;
        int k;
        bit narrow;
        int base;
        logic [VALUE_W-1:0] v;
        logic fin;
        begin
            target = words_sent + RANDOM_WORDS;
            while (words_sent < target)
            begin
                // A stretch in the middle runs with no idling on either side.
                calm = (words_sent > target - 100) && (words_sent < target - 60);
                len = ($urandom_range(99) < 20) ? CAPACITY : $urandom_range(1, CAPACITY - 1);
                narrow = 1'($urandom_range(1));
                base = $urandom_range(0, (1 << VALUE_W) - 1);
                for (k = 0; k < len; k++)
                begin
                    if (narrow)
                    begin
                        v = VALUE_W'(base + $urandom_range(0, 3));
                    end
                    else
                    begin
                        v = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
                    end
                    if (k + 1 < len)
                    begin
                        fin = 1'b0;
                    end
                    else if (len == CAPACITY)
                    begin
                        fin = 1'($urandom_range(1));
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                    send_word(v, fin);
                end
            end
            calm = 1'b0;
        end
    endtask

    // Sequence of the run.
    initial
    begin
        int waited;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_capacity_close();
        test_random_sets();

        // Leave the input idle and let the last report drain.
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending_reports.size() > 0 && waited < STALL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_reports.size() > 0)
        begin
            report_mismatch($sformatf("%0d expected result words never arrived",
                                      pending_reports.size()));
        end

        $display("Sent %0d words in %0d sets; checked %0d result words.",
                 words_sent, sets_closed, reports_checked);
        $display("Sets closed by marker and by reaching capacity, with random idling.");
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
